>>> hdl/fbps_pkg.sv
// Package for the fan button press sequencer.
// Holds the queue geometry, item mode codes and operation entry layout.
// No dependencies.
package fbps_pkg;

  // Operation queue geometry.
  localparam int QUEUE_DEPTH = 8;
  localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Field widths.
  localparam int TICK_W  = 16;
  localparam int RETRY_W = 4;
  localparam int SPEED_W = 2;
  localparam int MODE_W  = 2;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 16;

  // Register reset values.
  localparam logic [TICK_W-1:0]  PRESS_TICKS_RST   = TICK_W'(100);
  localparam logic [TICK_W-1:0]  RELEASE_TICKS_RST = TICK_W'(100);
  localparam logic [RETRY_W-1:0] MAX_RETRIES_RST   = RETRY_W'(3);

  // Item modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK    = 2'd0,
    MODE_COMMAND = 2'd1,
    MODE_RESYNC  = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [CIDX_W-1:0] {
    REG_PRESS_TICKS   = 2'd0,
    REG_RELEASE_TICKS = 2'd1,
    REG_MAX_RETRIES   = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  // Queued operation: kind plus target speed for speed presses.
  typedef struct packed {
    logic               is_speed;
    logic [SPEED_W-1:0] target;
  } op_entry_t;

  // Speed as shown by the two indicator LEDs.
  function automatic logic [SPEED_W-1:0] led_speed(input logic lo, input logic hi);
    led_speed = {hi, lo};
  endfunction

endpackage

>>> hdl/fan_button_press_sequencer_unit.sv
// Top level of the fan button press sequencer.
// Holds the operation queue, the press/release sequencer and the result register.
// Depends on fbps_pkg.
//
//   channel | direction | signals
//   --------+-----------+---------------------------------------------------
//   in      | sink      | in_valid, in_ready, mode, power_given, power_wanted,
//           |           | speed_given, speed_wanted, led_low, led_high
//   out     | source    | out_valid, out_ready, power_button, speed_button,
//           |           | fan_on, fan_speed, busy_res, op_dropped, gave_up
//   cfg     | sink      | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// Each input beat is processed combinationally; its result beat is in the result
// register on the following cycle. One beat per cycle is sustained while out_ready is high.
// A new input beat is taken whenever the result register is empty or being
// drained in the same cycle, so only a stalled output holds the input back.
// Synchronous reset clears the sequencer and queue pointers and presets the
// configuration registers; queue entries are written before they are read.
// Configuration writes are always taken.
module fan_button_press_sequencer_unit (
  input  logic                    clk,
  input  logic                    rst,
  // Input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [fbps_pkg::MODE_W-1:0]  mode,
  input  logic                    power_given,
  input  logic                    power_wanted,
  input  logic                    speed_given,
  input  logic [fbps_pkg::SPEED_W-1:0] speed_wanted,
  input  logic                    led_low,
  input  logic                    led_high,
  // Output channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    power_button,
  output logic                    speed_button,
  output logic                    fan_on,
  output logic [fbps_pkg::SPEED_W-1:0] fan_speed,
  output logic                    busy_res,
  output logic                    op_dropped,
  output logic                    gave_up,
  // Configuration channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [fbps_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [fbps_pkg::CDATA_W-1:0] cfg_data
);
  import fbps_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PRESS,
    PH_RELEASE
  } phase_t;

  // Configuration registers.
  logic [TICK_W-1:0]  press_ticks;
  logic [TICK_W-1:0]  release_ticks;
  logic [RETRY_W-1:0] max_retries;

  // Sequencer and reported state.
  phase_t             phase, phase_next;
  op_entry_t          active_op, active_op_next;
  logic [TICK_W-1:0]  phase_timer, phase_timer_next;
  logic [RETRY_W-1:0] retry_count, retry_count_next;
  logic               power_drive, power_drive_next;
  logic               speed_drive, speed_drive_next;
  logic               reported_on, reported_on_next;
  logic [SPEED_W-1:0] reported_speed, reported_speed_next;

  // Operation queue.
  op_entry_t          op_queue [QUEUE_DEPTH];
  logic [QIDX_W-1:0]  queue_head, queue_head_next;
  logic [QCNT_W-1:0]  queue_count, queue_count_next;

  // Queue write ports for one command beat.
  logic               wr0_en, wr1_en;
  logic [QIDX_W-1:0]  wr0_addr, wr1_addr;
  op_entry_t          wr1_data;

  logic               dropped, gave;
  logic               in_accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // Wrap a queue position that is known to lie below twice the depth.
  function automatic logic [QIDX_W-1:0] wrap_pos(input logic [QIDX_W+1:0] pos);
    logic [QIDX_W+1:0] adj;
    adj = pos;
    if (pos >= (QIDX_W+2)'(QUEUE_DEPTH)) begin
      adj = pos - (QIDX_W+2)'(QUEUE_DEPTH);
    end
    wrap_pos = adj[QIDX_W-1:0];
  endfunction

  // Next-state logic for one input beat.
  always_comb begin
    logic [TICK_W-1:0]  timer_inc;
    logic               power_change;
    logic               speed_diff;
    logic [QCNT_W-1:0]  count_mid;
    logic               on_mid;
    op_entry_t          head_op;

    phase_next          = phase;
    active_op_next      = active_op;
    phase_timer_next    = phase_timer;
    retry_count_next    = retry_count;
    power_drive_next    = power_drive;
    speed_drive_next    = speed_drive;
    reported_on_next    = reported_on;
    reported_speed_next = reported_speed;
    queue_head_next     = queue_head;
    queue_count_next    = queue_count;
    wr0_en   = 1'b0;
    wr1_en   = 1'b0;
    wr0_addr = wrap_pos((QIDX_W+2)'(queue_head) + (QIDX_W+2)'(queue_count));
    wr1_addr = wr0_addr;
    wr1_data = '{is_speed: 1'b1, target: speed_wanted};
    dropped  = 1'b0;
    gave     = 1'b0;
    head_op  = op_queue[queue_head];
    timer_inc = (phase_timer == '1) ? phase_timer : phase_timer + TICK_W'(1);
    power_change = 1'b0;
    speed_diff   = 1'b0;
    count_mid    = queue_count;
    on_mid       = reported_on;

    case (mode_t'(mode))
      MODE_TICK: begin
        unique case (phase)
          PH_IDLE: begin
            if (queue_count != '0) begin
              active_op_next   = head_op;
              queue_head_next  = wrap_pos((QIDX_W+2)'(queue_head) + (QIDX_W+2)'(1));
              queue_count_next = queue_count - QCNT_W'(1);
              phase_next       = PH_PRESS;
              phase_timer_next = '0;
              retry_count_next = '0;
              if (head_op.is_speed) begin
                speed_drive_next = 1'b1;
              end else begin
                power_drive_next = 1'b1;
              end
            end
          end
          PH_PRESS: begin
            phase_timer_next = timer_inc;
            if (timer_inc >= press_ticks) begin
              if (active_op.is_speed) begin
                speed_drive_next = 1'b0;
              end else begin
                power_drive_next = 1'b0;
              end
              phase_next       = PH_RELEASE;
              phase_timer_next = '0;
            end
          end
          PH_RELEASE: begin
            phase_timer_next = timer_inc;
            if (timer_inc >= release_ticks) begin
              if (!active_op.is_speed ||
                  led_speed(led_low, led_high) == active_op.target) begin
                phase_next     = PH_IDLE;
                active_op_next = '0;
              end else if (retry_count < max_retries) begin
                phase_next       = PH_PRESS;
                speed_drive_next = 1'b1;
                phase_timer_next = '0;
                retry_count_next = retry_count + RETRY_W'(1);
              end else begin
                phase_next     = PH_IDLE;
                active_op_next = '0;
                gave           = 1'b1;
              end
            end
          end
          default: begin
            phase_next = PH_IDLE;
          end
        endcase
      end
      MODE_COMMAND: begin
        // Power change goes in first, then the speed change behind it.
        power_change = power_given && (power_wanted != reported_on);
        if (power_change) begin
          if (queue_count >= QCNT_W'(QUEUE_DEPTH)) begin
            dropped = 1'b1;
          end else begin
            wr0_en    = 1'b1;
            count_mid = queue_count + QCNT_W'(1);
          end
          on_mid = power_wanted;
        end
        speed_diff = speed_given && (speed_wanted != reported_speed);
        if (speed_diff) begin
          if (on_mid || power_change) begin
            if (count_mid >= QCNT_W'(QUEUE_DEPTH)) begin
              dropped = 1'b1;
            end else begin
              wr1_en   = 1'b1;
              wr1_addr = wrap_pos((QIDX_W+2)'(queue_head) + (QIDX_W+2)'(count_mid));
            end
          end
          reported_speed_next = speed_wanted;
        end
        reported_on_next = on_mid;
        queue_count_next = count_mid + QCNT_W'(wr1_en);
      end
      MODE_RESYNC: begin
        reported_speed_next = led_speed(led_low, led_high);
        reported_on_next    = (led_speed(led_low, led_high) != '0);
      end
      default: begin
      end
    endcase
  end

  // State, configuration and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      press_ticks    <= PRESS_TICKS_RST;
      release_ticks  <= RELEASE_TICKS_RST;
      max_retries    <= MAX_RETRIES_RST;
      phase          <= PH_IDLE;
      active_op      <= '0;
      phase_timer    <= '0;
      retry_count    <= '0;
      power_drive    <= 1'b0;
      speed_drive    <= 1'b0;
      reported_on    <= 1'b0;
      reported_speed <= '0;
      queue_head     <= '0;
      queue_count    <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          REG_PRESS_TICKS:   press_ticks   <= cfg_data[TICK_W-1:0];
          REG_RELEASE_TICKS: release_ticks <= cfg_data[TICK_W-1:0];
          REG_MAX_RETRIES:   max_retries   <= cfg_data[RETRY_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        phase          <= phase_next;
        active_op      <= active_op_next;
        phase_timer    <= phase_timer_next;
        retry_count    <= retry_count_next;
        power_drive    <= power_drive_next;
        speed_drive    <= speed_drive_next;
        reported_on    <= reported_on_next;
        reported_speed <= reported_speed_next;
        queue_head     <= queue_head_next;
        queue_count    <= queue_count_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload, loaded with the state after each input beat.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      power_button <= power_drive_next;
      speed_button <= speed_drive_next;
      fan_on       <= reported_on_next;
      fan_speed    <= reported_speed_next;
      busy_res     <= (phase_next != PH_IDLE) || (queue_count_next != '0);
      op_dropped   <= dropped;
      gave_up      <= gave;
    end
  end

  // Queue entry writes.
  always_ff @(posedge clk) begin
    if (in_accept && wr0_en) begin
      op_queue[wr0_addr] <= '0;
    end
    if (in_accept && wr1_en) begin
      op_queue[wr1_addr] <= wr1_data;
    end
  end

`ifndef SYNTHESIS
  a_one_button: assert property (@(posedge clk) disable iff (rst)
    !(power_drive && speed_drive))
    else $error("both buttons driven at once");

  a_idle_released: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (!power_drive && !speed_drive))
    else $error("button driven while sequencer idle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    queue_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_busy_matches: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (busy_res == ((phase != PH_IDLE) || (queue_count != '0))))
    else $error("busy flag disagrees with sequencer state");
`endif

endmodule
